### hdl/dbss_pkg.sv
// Shared types and constants for the double-buffered snapshot store.
package dbss_pkg;

    localparam int INDEX_W = 16;
    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 11;
    localparam int MARK_W  = 2;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CKPT  = 2'd2;

    localparam logic [MARK_W-1:0] MARK_NONE  = 2'd0;
    localparam logic [MARK_W-1:0] ACTIVE_ONE = 2'd1;
    localparam logic [MARK_W-1:0] ACTIVE_TWO = 2'd2;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

    localparam logic [7:0]  FILL_BYTE = 8'h53;
    localparam logic [63:0] FILL_WORD = {8{FILL_BYTE}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_MERGE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

### hdl/dbss_req_if.sv
// Request channel: operation, index and write value with valid/ready.
interface dbss_req_if;
    logic                            valid;
    logic                            ready;
    logic [dbss_pkg::OP_W-1:0]       op;
    logic [dbss_pkg::INDEX_W-1:0]    index;
    logic [dbss_pkg::VALUE_W-1:0]    write_value;

    modport source (output valid, output op, output index, output write_value, input ready);
    modport sink (input valid, input op, input index, input write_value, output ready);
endinterface

### hdl/dbss_rsp_if.sv
// Response channel: read data and active copy number with valid/ready.
interface dbss_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [dbss_pkg::VALUE_W-1:0]   read_data;
    logic [dbss_pkg::MARK_W-1:0]    active_after;

    modport source (output valid, output read_data, output active_after, input ready);
    modport sink (input valid, input read_data, input active_after, output ready);
endinterface

### hdl/double_buffered_snapshot_store.sv
// Top level of the double-buffered snapshot store with two copies and per-entry marks.
// One item is handled at a time; the next beat is accepted once the result is registered.
// Read: the 16-step remainder unit, then the registered RAM read, then the result; a write
// adds a merge step. Checkpoint: walks the entries in use, one entry per cycle of the walk.
// An unused op goes straight to the result. After reset a clearing pass over all DEPTH entries
// fills both copies with 0x53 bytes and the marks with zero before the first beat is accepted.
module double_buffered_snapshot_store #(
    parameter int DEPTH      = 1024,
    parameter int ENTRY_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [dbss_pkg::CFG_W-1:0]    cfg_wdata,
    dbss_req_if.sink                      req,
    dbss_rsp_if.source                    rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int UW = $clog2(DEPTH + 1);
    localparam int LW = (ENTRY_BITS < 32) ? ENTRY_BITS : 32;
    localparam int MW = dbss_pkg::MARK_W;

    dbss_pkg::state_t state_reg;
    dbss_pkg::state_t state_next;

    logic [dbss_pkg::CFG_W-1:0]   entries_reg;
    logic [UW-1:0]                used;
    logic [dbss_pkg::OP_W-1:0]    op_reg;
    logic [dbss_pkg::OP_W-1:0]    op_next;
    logic [dbss_pkg::VALUE_W-1:0] wval_reg;
    logic [dbss_pkg::VALUE_W-1:0] wval_next;
    logic [MW-1:0]                active_reg;
    logic [MW-1:0]                active_next;
    logic [AW-1:0]                clr_reg;
    logic [AW-1:0]                clr_next;
    logic [UW-1:0]                walk_reg;
    logic [UW-1:0]                walk_next;
    logic                         pv_reg;
    logic                         pv_next;
    logic [AW-1:0]                pa_reg;
    logic [AW-1:0]                pa_next;
    logic                         out_vld_reg;
    logic                         out_vld_next;
    logic [dbss_pkg::VALUE_W-1:0] out_data_reg;
    logic [dbss_pkg::VALUE_W-1:0] out_data_next;
    logic [MW-1:0]                out_act_reg;
    logic [MW-1:0]                out_act_next;

    logic                  mod_start;
    logic                  mod_done;
    logic [UW-1:0]         mod_rem;
    logic [AW-1:0]         slot;

    logic                  c1_we;
    logic                  c2_we;
    logic                  mk_we;
    logic                  rd_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [ENTRY_BITS-1:0] wr_data;
    logic [MW-1:0]         mk_wdata;
    logic [ENTRY_BITS-1:0] c1_rdata;
    logic [ENTRY_BITS-1:0] c2_rdata;
    logic [MW-1:0]         mk_rdata;
    logic                  act_one;
    logic [ENTRY_BITS-1:0] act_rdata;
    logic [ENTRY_BITS-1:0] frz_rdata;
    logic [ENTRY_BITS-1:0] merged;
    logic [ENTRY_BITS-1:0] fill;
    logic                  slot_free;

    always_comb
    begin
        if (entries_reg == '0)
        begin
            used = UW'(1);
        end
        else if (32'(entries_reg) > 32'(DEPTH))
        begin
            used = UW'(DEPTH);
        end
        else
        begin
            used = UW'(entries_reg);
        end
    end

    dbss_mod #(
        .NW (UW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.index),
        .divisor   (used),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign slot      = mod_rem[AW-1:0];
    assign act_one   = (active_reg == dbss_pkg::ACTIVE_ONE);
    assign act_rdata = act_one ? c1_rdata : c2_rdata;
    assign frz_rdata = act_one ? c2_rdata : c1_rdata;
    assign fill      = ENTRY_BITS'(dbss_pkg::FILL_WORD);
    assign slot_free = !out_vld_reg || rsp.ready;

    always_comb
    begin
        merged         = act_rdata;
        merged[LW-1:0] = wval_reg[LW-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        wval_next     = wval_reg;
        active_next   = active_reg;
        clr_next      = clr_reg;
        walk_next     = walk_reg;
        pv_next       = pv_reg;
        pa_next       = pa_reg;
        out_vld_next  = out_vld_reg && !rsp.ready;
        out_data_next = out_data_reg;
        out_act_next  = out_act_reg;
        mod_start     = 1'b0;
        c1_we         = 1'b0;
        c2_we         = 1'b0;
        mk_we         = 1'b0;
        rd_en         = 1'b0;
        wr_addr       = slot;
        rd_addr       = slot;
        wr_data       = merged;
        mk_wdata      = active_reg;
        req.ready     = 1'b0;

        unique case (state_reg)
            dbss_pkg::ST_CLEAR:
            begin
                c1_we    = 1'b1;
                c2_we    = 1'b1;
                mk_we    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = fill;
                mk_wdata = dbss_pkg::MARK_NONE;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = dbss_pkg::ST_IDLE;
                end
            end
            dbss_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next   = req.op;
                    wval_next = req.write_value;
                    if ((req.op == dbss_pkg::OP_READ) || (req.op == dbss_pkg::OP_WRITE))
                    begin
                        mod_start  = 1'b1;
                        state_next = dbss_pkg::ST_DIV;
                    end
                    else if (req.op == dbss_pkg::OP_CKPT)
                    begin
                        active_next = act_one ? dbss_pkg::ACTIVE_TWO : dbss_pkg::ACTIVE_ONE;
                        walk_next   = '0;
                        pv_next     = 1'b0;
                        state_next  = dbss_pkg::ST_WALK;
                    end
                    else
                    begin
                        state_next = dbss_pkg::ST_DONE;
                    end
                end
            end
            dbss_pkg::ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = dbss_pkg::ST_FETCH;
                end
            end
            dbss_pkg::ST_FETCH:
            begin
                rd_en = 1'b1;
                if (op_reg == dbss_pkg::OP_WRITE)
                begin
                    state_next = dbss_pkg::ST_MERGE;
                end
                else
                begin
                    state_next = dbss_pkg::ST_DONE;
                end
            end
            dbss_pkg::ST_MERGE:
            begin
                c1_we      = act_one;
                c2_we      = !act_one;
                mk_we      = 1'b1;
                state_next = dbss_pkg::ST_DONE;
            end
            dbss_pkg::ST_WALK:
            begin
                rd_addr = walk_reg[AW-1:0];
                wr_addr = pa_reg;
                wr_data = frz_rdata;
                if (walk_reg < used)
                begin
                    rd_en     = 1'b1;
                    pv_next   = 1'b1;
                    pa_next   = walk_reg[AW-1:0];
                    walk_next = walk_reg + UW'(1);
                end
                else
                begin
                    pv_next    = 1'b0;
                    state_next = dbss_pkg::ST_DONE;
                end
                if (pv_reg && (mk_rdata != active_reg))
                begin
                    c1_we    = act_one;
                    c2_we    = !act_one;
                    mk_we    = 1'b1;
                    mk_wdata = dbss_pkg::MARK_NONE;
                end
            end
            dbss_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    out_vld_next = 1'b1;
                    out_act_next = active_reg;
                    if (op_reg == dbss_pkg::OP_READ)
                    begin
                        out_data_next = dbss_pkg::VALUE_W'(act_rdata[LW-1:0]);
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                    state_next = dbss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dbss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dbss_pkg::ST_CLEAR;
            entries_reg <= dbss_pkg::ENTRIES_RESET;
            active_reg  <= dbss_pkg::ACTIVE_ONE;
            clr_reg     <= '0;
            walk_reg    <= '0;
            pv_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            clr_reg     <= clr_next;
            walk_reg    <= walk_next;
            pv_reg      <= pv_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wen)
            begin
                entries_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        wval_reg     <= wval_next;
        pa_reg       <= pa_next;
        out_data_reg <= out_data_next;
        out_act_reg  <= out_act_next;
    end

    dbss_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_copy_one (
        .clk   (clk),
        .we    (c1_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (c1_rdata)
    );

    dbss_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_copy_two (
        .clk   (clk),
        .we    (c2_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (c2_rdata)
    );

    dbss_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_marks (
        .clk   (clk),
        .we    (mk_we),
        .waddr (wr_addr),
        .wdata (mk_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (mk_rdata)
    );

    assign rsp.valid        = out_vld_reg;
    assign rsp.read_data    = out_data_reg;
    assign rsp.active_after = out_act_reg;

endmodule

### hdl/dbss_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dbss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/dbss_mod.sv
// Iterative remainder unit that reduces an index modulo a divisor, one bit per cycle.
module dbss_mod #(
    parameter int NW = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dbss_pkg::INDEX_W-1:0]   dividend,
    input  logic [NW-1:0]                  divisor,
    output logic                           done,
    output logic [NW-1:0]                  remainder
);

    localparam int DW = dbss_pkg::INDEX_W;
    localparam int CW = $clog2(DW);

    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] dvd_next;
    logic [NW-1:0] div_reg;
    logic [NW-1:0] div_next;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] rem_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic [NW:0]   trial;
    logic [NW:0]   diff;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(DW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[NW-1:0];
            end
            else
            begin
                rem_next = trial[NW-1:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == '0);
    assign remainder = rem_reg;

endmodule
